// File: src/lmm_pkg.sv
// lmm_pkg: shared constants and types of the link metrics monitor
// no dependencies
`timescale 1ns / 1ps
package lmm_pkg;
	localparam int RING_DEPTH_DEF = 1024;
	localparam int SEQ_SPACE_DEF  = 65536;

	localparam logic [15:0] GAP_LIMIT_RST = 16'd5000;
	localparam logic [15:0] FC_DATA       = 16'h0008;
	localparam logic [15:0] FC_ACK        = 16'h2B00;

	// sample ring ids
	localparam logic [1:0] RING_LAT  = 2'd0;
	localparam logic [1:0] RING_GAP  = 2'd1;
	localparam logic [1:0] RING_SNR  = 2'd2;
	localparam logic [1:0] RING_CONT = 2'd3;

	// configuration register indexes
	localparam logic REG_GAP_LIMIT = 1'b0;

	typedef enum logic [2:0] {
		REQ_SRC = 3'd0,
		REQ_TX  = 3'd1,
		REQ_RX  = 3'd2,
		REQ_DEQ = 3'd3,
		REQ_SNR = 3'd4,
		REQ_RPT = 3'd5
	} req_t;
endpackage

// File: src/link_metrics_monitor.sv
// link_metrics_monitor: mac link statistics engine, top level
// depends on lmm_pkg, lmm_ram, lmm_div, lmm_apb
`timescale 1ns / 1ps
// usage
// - command channel: an event is taken on a clock edge with start high and busy low;
//   req_type selects new source frame, transmit, received frame, dequeue, snr or report
// - result channel: a report produces one beat, shown for a single cycle with done
//   high; the receiver cannot stall, so the beat must be captured in that cycle
// - config: apb port, one register (gap_limit_ms at byte 0), pready tied high
// timing
// - dequeue, snr, source frame, retransmit, unmatched frames, ignored events: handled in S_EXEC
// - new send and matching ack: also pass S_STAMP, for the registered read of the stamp ram
// - report: walks every sample of the four rings over the single sample ram read
//   port, then runs up to 7 divides on the shared bit-serial divider; whole
//   seconds come from a combinational reciprocal multiply
// - done appears in the last busy cycle of a report; busy drops the next cycle
// reset
// - counters, headers, ring fill and head pointers clear, the config register loads 5000;
//   stamp and sample rams are not cleared and need no clearing pass
module link_metrics_monitor #(
	parameter int RING_DEPTH = lmm_pkg::RING_DEPTH_DEF,
	parameter int SEQ_SPACE  = lmm_pkg::SEQ_SPACE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// command channel
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  req_type,
	input  logic [31:0] time_ms,
	input  logic [15:0] fc_word,
	input  logic [15:0] duration,
	input  logic [47:0] addr1,
	input  logic [47:0] addr2,
	input  logic [47:0] addr3,
	input  logic [15:0] seq_nr,
	input  logic signed [15:0] snr_db,
	// result channel
	output logic        done,
	output logic [31:0] lat_avg,
	output logic [31:0] jitter_avg,
	output logic [31:0] interpkt_avg,
	output logic signed [31:0] rnp,
	output logic [31:0] throughput,
	output logic signed [15:0] snr_avg,
	output logic [31:0] cont_avg,
	output logic [15:0] buffer_estimate,
	// config port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import lmm_pkg::*;

	localparam int IW    = $clog2(RING_DEPTH);      // ring index
	localparam int FW    = $clog2(RING_DEPTH + 1);  // ring fill count
	localparam int PW    = FW + 1;                  // pointer arithmetic, holds 2*depth
	localparam int SW    = $clog2(SEQ_SPACE);       // stamp slot
	localparam int SUM_W = 32 + FW;
	localparam int DW    = SUM_W + 8;
	localparam int RA_W  = IW + 2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_STAMP,
		S_WALK,
		S_DIVGO,
		S_DIVWAIT,
		S_OUT
	} state_t;

	typedef enum logic [2:0] {
		OP_LAT,
		OP_JIT,
		OP_GAP,
		OP_SNR,
		OP_CONT,
		OP_RNP,
		OP_SECS,
		OP_THR
	} op_t;

	// seq modulo the stamp space, quotient fits 8 bits
	function automatic logic [SW-1:0] seq_slot(input logic [15:0] v);
		logic [24:0] r;
		r = {9'b0, v};
		for (int k = 7; k >= 0; k--) begin
			if (r >= (25'(SEQ_SPACE) << k)) begin
				r = r - (25'(SEQ_SPACE) << k);
			end
		end
		return r[SW-1:0];
	endfunction

	function automatic logic [31:0] sat32(input logic [DW-1:0] v);
		return (|v[DW-1:32]) ? 32'hFFFF_FFFF : v[31:0];
	endfunction

	state_t state_q;
	op_t    op_q;

	// latched event
	logic [2:0]  req_q;
	logic [31:0] time_q;
	logic [15:0] fc_q;
	logic [15:0] dur_q;
	logic [47:0] a1_q;
	logic [47:0] a2_q;
	logic [47:0] a3_q;
	logic [15:0] seq_q;
	logic [15:0] snr_q;

	// link state
	logic [31:0] cur_fd_q;
	logic [47:0] cur_a_q;
	logic [47:0] cur_b_q;
	logic [47:0] cur_c_q;
	logic [15:0] cur_seq_q;
	logic [31:0] cnt_tx_q;
	logic [31:0] cnt_retx_q;
	logic [31:0] cnt_ack_q;
	logic [15:0] last_src_q;
	logic [31:0] last_arr_q;
	logic [31:0] win_q;
	logic [FW-1:0] fill_q [4];
	logic [IW-1:0] head_q [4];

	// report walk
	logic [1:0]    ring_q;
	logic [FW-1:0] idx_q;
	logic          rv_s1;
	logic [1:0]    rring_s1;
	logic          jfirst_q;
	logic [31:0]   prev_q;
	logic [SUM_W-1:0] lat_sum_q;
	logic [SUM_W-1:0] jit_sum_q;
	logic [SUM_W-1:0] gap_sum_q;
	logic [SUM_W-1:0] cont_sum_q;
	logic signed [SUM_W-1:0] snr_sum_q;
	logic [31:0]   secs_q;

	// result registers
	logic        done_q;
	logic [31:0] lat_avg_q;
	logic [31:0] jit_avg_q;
	logic [31:0] gap_avg_q;
	logic [31:0] rnp_q;
	logic [31:0] thr_q;
	logic [15:0] snr_avg_q;
	logic [31:0] cont_avg_q;
	logic [15:0] buf_q;

	logic [15:0] gap_limit;
	logic        accept;

	// ram ports
	logic [SW-1:0]   slot;
	logic            st_we;
	logic            st_re;
	logic [31:0]     st_rdata;
	logic            rg_we;
	logic [RA_W-1:0] rg_waddr;
	logic [31:0]     rg_wdata;
	logic            rg_re;
	logic [RA_W-1:0] rg_raddr;
	logic [31:0]     rg_rdata;

	// push
	logic        push_en;
	logic [1:0]  push_ring;
	logic [31:0] push_val;
	logic [31:0] gap;

	// compares
	logic tx_data;
	logic tx_same;
	logic rx_match;

	// walk address
	logic [PW-1:0] base;
	logic [PW-1:0] pos;
	logic          issue;

	// divider
	logic          div_start;
	logic [DW-1:0] div_dend;
	logic [31:0]   div_dsor;
	logic          div_zero;
	logic          div_done;
	logic [DW-1:0] div_quo;
	logic [32:0]   tot;
	logic [SUM_W-1:0] snr_abs;
	logic [16:0]   be_diff;

	// whole seconds of the window by reciprocal multiply
	logic [61:0]   secs_prod;
	logic [31:0]   secs_calc;

	lmm_apb u_apb (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.gap_limit (gap_limit)
	);

	lmm_ram #(.W(32), .AW(SW), .DEPTH(SEQ_SPACE)) u_stamp (
		.clk   (clk),
		.we    (st_we),
		.waddr (slot),
		.wdata (time_q),
		.re    (st_re),
		.raddr (slot),
		.rdata (st_rdata)
	);

	lmm_ram #(.W(32), .AW(RA_W), .DEPTH(4 << IW)) u_rings (
		.clk   (clk),
		.we    (rg_we),
		.waddr (rg_waddr),
		.wdata (rg_wdata),
		.re    (rg_re),
		.raddr (rg_raddr),
		.rdata (rg_rdata)
	);

	lmm_div #(.DW(DW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dend),
		.divisor  (div_dsor),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign busy   = state_q != S_IDLE;
	assign accept = start && !busy;

	assign slot  = seq_slot(seq_q);
	assign st_we = state_q == S_EXEC && req_q == REQ_DEQ;
	assign st_re = state_q == S_EXEC;

	assign tx_data  = fc_q == FC_DATA;
	assign tx_same  = {fc_q, dur_q} == cur_fd_q && a1_q == cur_a_q && a2_q == cur_b_q
		&& a3_q == cur_c_q && seq_q == cur_seq_q;
	assign rx_match = fc_q == FC_ACK && a1_q == cur_b_q && a2_q == cur_a_q
		&& seq_q == cur_seq_q;

	assign gap = time_q - last_arr_q;

	// sample push into the rings
	always_comb begin
		push_en   = 1'b0;
		push_ring = RING_GAP;
		push_val  = gap;
		if (state_q == S_EXEC) begin
			case (req_q)
				REQ_SRC: begin
					push_en = gap < {16'b0, gap_limit};
				end
				REQ_SNR: begin
					push_en   = 1'b1;
					push_ring = RING_SNR;
					push_val  = {16'b0, snr_q};
				end
				default: begin
					push_en = 1'b0;
				end
			endcase
		end else if (state_q == S_STAMP) begin
			push_en   = 1'b1;
			push_ring = (req_q == REQ_TX) ? RING_CONT : RING_LAT;
			push_val  = time_q - st_rdata;
		end
	end

	assign rg_we    = push_en;
	assign rg_waddr = {push_ring, head_q[push_ring]};
	assign rg_wdata = push_val;

	// oldest entry of the ring under walk, then the entry idx_q after it
	always_comb begin
		base = PW'(head_q[ring_q]) + PW'(RING_DEPTH) - PW'(fill_q[ring_q]);
		if (base >= PW'(RING_DEPTH)) begin
			base = base - PW'(RING_DEPTH);
		end
		pos = base + PW'(idx_q);
		if (pos >= PW'(RING_DEPTH)) begin
			pos = pos - PW'(RING_DEPTH);
		end
	end

	assign issue    = state_q == S_WALK && idx_q < fill_q[ring_q];
	assign rg_re    = issue;
	assign rg_raddr = {ring_q, pos[IW-1:0]};

	assign tot     = {1'b0, cnt_tx_q} + {1'b0, cnt_retx_q};
	assign snr_abs = snr_sum_q < 0 ? SUM_W'(-snr_sum_q) : SUM_W'(snr_sum_q);
	assign be_diff = {1'b0, last_src_q} - {1'b0, cur_seq_q}
		+ ((last_src_q >= cur_seq_q) ? 17'd0 : 17'(SEQ_SPACE));

	// floor(x / 1000) = (x * ceil(2^38 / 1000)) >> 38, exact for any 32-bit x
	assign secs_prod = 62'(time_q - win_q) * 62'(30'd274877907);
	assign secs_calc = {8'b0, secs_prod[61:38]};

	// operands of the current report divide; zero means the special value applies
	always_comb begin
		div_dend = {lat_sum_q, 8'b0};
		div_dsor = 32'(fill_q[RING_LAT]);
		div_zero = 1'b0;
		case (op_q)
			OP_LAT: begin
				div_zero = fill_q[RING_LAT] == '0;
			end
			OP_JIT: begin
				div_dend = {jit_sum_q, 8'b0};
				div_dsor = 32'(fill_q[RING_LAT] - 1'b1);
				div_zero = fill_q[RING_LAT] < FW'(2);
			end
			OP_GAP: begin
				div_dend = {gap_sum_q, 8'b0};
				div_dsor = 32'(fill_q[RING_GAP]);
				div_zero = fill_q[RING_GAP] == '0;
			end
			OP_SNR: begin
				div_dend = DW'(snr_abs);
				div_dsor = 32'(fill_q[RING_SNR]);
				div_zero = fill_q[RING_SNR] == '0;
			end
			OP_CONT: begin
				div_dend = {cont_sum_q, 8'b0};
				div_dsor = 32'(fill_q[RING_CONT]);
				div_zero = fill_q[RING_CONT] == '0;
			end
			OP_RNP: begin
				div_dend = DW'(tot);
				div_dsor = cnt_ack_q;
				div_zero = tot == '0 || cnt_ack_q == '0;
			end
			// seconds come from the multiply, no divide needed
			OP_SECS: begin
				div_zero = 1'b1;
			end
			OP_THR: begin
				div_dend = DW'({cnt_ack_q, 8'b0});
				div_dsor = secs_q;
				div_zero = secs_q == '0;
			end
			default: begin
				div_zero = 1'b1;
			end
		endcase
	end

	assign div_start = state_q == S_DIVGO && !div_zero;

	// latch the event on accept
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q  <= req_type;
			time_q <= time_ms;
			fc_q   <= fc_word;
			dur_q  <= duration;
			a1_q   <= addr1;
			a2_q   <= addr2;
			a3_q   <= addr3;
			seq_q  <= seq_nr;
			snr_q  <= snr_db;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			op_q       <= OP_LAT;
			cur_fd_q   <= '0;
			cur_a_q    <= '0;
			cur_b_q    <= '0;
			cur_c_q    <= '0;
			cur_seq_q  <= '0;
			cnt_tx_q   <= '0;
			cnt_retx_q <= '0;
			cnt_ack_q  <= '0;
			last_src_q <= '0;
			last_arr_q <= '0;
			win_q      <= '0;
			for (int r = 0; r < 4; r++) begin
				fill_q[r] <= '0;
				head_q[r] <= '0;
			end
			ring_q     <= '0;
			idx_q      <= '0;
			rv_s1      <= 1'b0;
			rring_s1   <= '0;
			jfirst_q   <= 1'b1;
			prev_q     <= '0;
			lat_sum_q  <= '0;
			jit_sum_q  <= '0;
			gap_sum_q  <= '0;
			cont_sum_q <= '0;
			snr_sum_q  <= '0;
			secs_q     <= '0;
			done_q     <= 1'b0;
			lat_avg_q  <= '0;
			jit_avg_q  <= '0;
			gap_avg_q  <= '0;
			rnp_q      <= '0;
			thr_q      <= '0;
			snr_avg_q  <= '0;
			cont_avg_q <= '0;
			buf_q      <= '0;
		end else begin
			done_q <= 1'b0;

			// ring pointer update on every push
			if (push_en) begin
				head_q[push_ring] <= (head_q[push_ring] == IW'(RING_DEPTH - 1))
					? '0 : head_q[push_ring] + 1'b1;
				if (fill_q[push_ring] < FW'(RING_DEPTH)) begin
					fill_q[push_ring] <= fill_q[push_ring] + 1'b1;
				end
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EXEC;
					end
				end

				S_EXEC: begin
					state_q <= S_IDLE;
					case (req_q)
						REQ_SRC: begin
							last_src_q <= seq_q;
							last_arr_q <= time_q;
						end
						REQ_TX: begin
							if (tx_data) begin
								if (tx_same) begin
									cnt_retx_q <= cnt_retx_q + 1'b1;
								end else begin
									cur_fd_q  <= {fc_q, dur_q};
									cur_a_q   <= a1_q;
									cur_b_q   <= a2_q;
									cur_c_q   <= a3_q;
									cur_seq_q <= seq_q;
									cnt_tx_q  <= cnt_tx_q + 1'b1;
									state_q   <= S_STAMP;
								end
							end
						end
						REQ_RX: begin
							if (rx_match) begin
								cnt_ack_q <= cnt_ack_q + 1'b1;
								state_q   <= S_STAMP;
							end
						end
						REQ_RPT: begin
							state_q    <= S_WALK;
							ring_q     <= RING_LAT;
							idx_q      <= '0;
							rv_s1      <= 1'b0;
							jfirst_q   <= 1'b1;
							lat_sum_q  <= '0;
							jit_sum_q  <= '0;
							gap_sum_q  <= '0;
							cont_sum_q <= '0;
							snr_sum_q  <= '0;
						end
						default: begin
							state_q <= S_IDLE;
						end
					endcase
				end

				// stamp data is back, the push happens in this cycle
				S_STAMP: begin
					state_q <= S_IDLE;
				end

				S_WALK: begin
					rv_s1    <= issue;
					rring_s1 <= ring_q;
					if (issue) begin
						idx_q <= idx_q + 1'b1;
					end
					if (rv_s1) begin
						case (rring_s1)
							RING_LAT: begin
								lat_sum_q <= lat_sum_q + SUM_W'(rg_rdata);
								if (!jfirst_q) begin
									jit_sum_q <= jit_sum_q + SUM_W'((rg_rdata > prev_q)
										? rg_rdata - prev_q : prev_q - rg_rdata);
								end
								prev_q   <= rg_rdata;
								jfirst_q <= 1'b0;
							end
							RING_GAP: begin
								gap_sum_q <= gap_sum_q + SUM_W'(rg_rdata);
							end
							RING_SNR: begin
								snr_sum_q <= snr_sum_q
									+ {{(SUM_W - 16){rg_rdata[15]}}, rg_rdata[15:0]};
							end
							default: begin
								cont_sum_q <= cont_sum_q + SUM_W'(rg_rdata);
							end
						endcase
					end
					if (!issue && !rv_s1) begin
						if (ring_q == RING_CONT) begin
							state_q <= S_DIVGO;
							op_q    <= OP_LAT;
						end else begin
							ring_q <= ring_q + 1'b1;
							idx_q  <= '0;
						end
					end
				end

				S_DIVGO: begin
					if (div_zero) begin
						case (op_q)
							OP_LAT:  lat_avg_q  <= '0;
							OP_JIT:  jit_avg_q  <= '0;
							OP_GAP:  gap_avg_q  <= '0;
							OP_SNR:  snr_avg_q  <= '0;
							OP_CONT: cont_avg_q <= '0;
							OP_RNP:  rnp_q      <= '0;
							OP_THR:  thr_q      <= (cnt_ack_q != '0) ? 32'hFFFF_FFFF : '0;
							default: secs_q     <= secs_calc;
						endcase
						if (op_q == OP_THR) begin
							state_q <= S_OUT;
							done_q  <= 1'b1;
							buf_q   <= be_diff[15:0];
						end else begin
							op_q <= op_t'(op_q + 3'd1);
						end
					end else begin
						state_q <= S_DIVWAIT;
					end
				end

				S_DIVWAIT: begin
					if (div_done) begin
						case (op_q)
							OP_LAT:  lat_avg_q  <= sat32(div_quo);
							OP_JIT:  jit_avg_q  <= sat32(div_quo);
							OP_GAP:  gap_avg_q  <= sat32(div_quo);
							OP_SNR:  snr_avg_q  <= (snr_sum_q < 0)
								? 16'(-div_quo[15:0]) : div_quo[15:0];
							OP_CONT: cont_avg_q <= sat32(div_quo);
							OP_RNP: begin
								if (div_quo == '0) begin
									rnp_q <= 32'hFFFF_FFFF;
								end else if (div_quo - 1'b1 > DW'(32'h7FFF_FFFF)) begin
									rnp_q <= 32'h7FFF_FFFF;
								end else begin
									rnp_q <= 32'(div_quo - 1'b1);
								end
							end
							default: thr_q  <= sat32(div_quo);
						endcase
						if (op_q == OP_THR) begin
							state_q <= S_OUT;
							done_q  <= 1'b1;
							buf_q   <= be_diff[15:0];
						end else begin
							op_q    <= op_t'(op_q + 3'd1);
							state_q <= S_DIVGO;
						end
					end
				end

				// result beat is on the ports now; restart the window
				S_OUT: begin
					for (int r = 0; r < 4; r++) begin
						fill_q[r] <= '0;
					end
					cnt_tx_q   <= '0;
					cnt_retx_q <= '0;
					cnt_ack_q  <= '0;
					win_q      <= time_q;
					state_q    <= S_IDLE;
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done            = done_q;
	assign lat_avg         = lat_avg_q;
	assign jitter_avg      = jit_avg_q;
	assign interpkt_avg    = gap_avg_q;
	assign rnp             = rnp_q;
	assign throughput      = thr_q;
	assign snr_avg         = snr_avg_q;
	assign cont_avg        = cont_avg_q;
	assign buffer_estimate = buf_q;
endmodule

// File: src/lmm_ram.sv
// lmm_ram: simple dual-port synchronous ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps
module lmm_ram #(
	parameter int W     = 32,
	parameter int AW    = 10,
	parameter int DEPTH = 1024
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);
	logic [W-1:0] mem [DEPTH];
	logic [W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

// File: src/lmm_div.sv
// lmm_div: restoring divider, one quotient bit per cycle
// no dependencies
`timescale 1ns / 1ps
module lmm_div #(
	parameter int DW = 51
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [31:0]   divisor,
	output logic          done,
	output logic [DW-1:0] quotient
);
	localparam int CW = $clog2(DW + 1);

	logic          run_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [31:0]   rem_q;
	logic [31:0]   dsor_q;
	logic [DW-1:0] quo_q;
	logic [32:0]   trial;
	logic          ge;

	assign trial = {rem_q, quo_q[DW-1]};
	assign ge    = trial >= {1'b0, dsor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(DW - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q  <= dividend;
			rem_q  <= '0;
			dsor_q <= divisor;
		end else if (run_q) begin
			rem_q <= ge ? 32'(trial - {1'b0, dsor_q}) : trial[31:0];
			quo_q <= {quo_q[DW-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule

// File: src/lmm_apb.sv
// lmm_apb: configuration register file behind the apb port
// depends on lmm_pkg
`timescale 1ns / 1ps
module lmm_apb (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [15:0] gap_limit
);
	import lmm_pkg::*;

	logic [15:0] gap_limit_q;
	logic        wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_limit_q <= GAP_LIMIT_RST;
		end else if (wr_en && paddr[2] == REG_GAP_LIMIT) begin
			gap_limit_q <= pwdata[15:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_GAP_LIMIT) begin
			prdata = {16'b0, gap_limit_q};
		end
	end

	assign gap_limit = gap_limit_q;
endmodule

// File: src/lmm_checker.sv
// lmm_checker: port-level checks of the link metrics monitor, bound to the top level
// depends on link_metrics_monitor
`timescale 1ns / 1ps
module lmm_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic psel,
	input logic penable,
	input logic pready
);
	// a result only comes out of a report still in progress
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("result beat while idle");

	// a result beat is never repeated back to back
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result beat repeated");

	// the block goes idle right after the result beat
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy) else $error("busy after result beat");

	// an accepted event always occupies the block
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("accept did not raise busy");

	// config access completes without wait states
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable) |-> pready) else $error("config wait state");
endmodule

bind link_metrics_monitor lmm_checker u_lmm_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.start   (start),
	.busy    (busy),
	.done    (done),
	.psel    (psel),
	.penable (penable),
	.pready  (pready)
);
